// ===== rtl/core/tlpt_pkg.sv =====
// Shared types, sizes and codes of the two-level page table engine.
package tlpt_pkg;

   // Directory and page table geometry.
   localparam int MAX_TABLES        = 16;
   localparam int ENTRIES_PER_TABLE = 1024;
   localparam int IDX_W             = 10;
   localparam int DIR_W             = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
   localparam int PT_DEPTH          = MAX_TABLES * ENTRIES_PER_TABLE;
   localparam int ADDR_W            = $clog2(PT_DEPTH);
   localparam int CNT_W             = (DIR_W + 1 > 6) ? DIR_W + 1 : 6;

   // Entry layout: frame number over user, writable and present flags.
   localparam int FRAME_W = 20;
   localparam int ENTRY_W = FRAME_W + 3;
   localparam int OFFS_W  = 12;

   // Field widths.
   localparam int MODE_W = 2;
   localparam int VA_W   = 32;
   localparam int STAT_W = 3;
   localparam int MB_W   = 7;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_INIT      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAP       = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNMAP     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TRANSLATE = 2'd3;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK              = 3'd0;
   localparam logic [STAT_W-1:0] ST_VIRT_MISALIGNED = 3'd1;
   localparam logic [STAT_W-1:0] ST_PHYS_MISALIGNED = 3'd2;
   localparam logic [STAT_W-1:0] ST_ALREADY_MAPPED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_MAPPED      = 3'd4;
   localparam logic [STAT_W-1:0] ST_NO_TABLE        = 3'd5;

   // Directory control: reload marks the first count tables present.
   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] count;
   } dir_ctrl_type;

endpackage

// ===== rtl/core/tlpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tlpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tlpt_dir.sv =====
// Page directory: one present bit per table and the table lookup.
module tlpt_dir (
   input  logic                       clock,
   input  logic                       reset,
   input  tlpt_pkg::dir_ctrl_type     ctrl,
   input  logic [tlpt_pkg::IDX_W-1:0] lookup_dir,
   output logic                       hit
);

   logic [tlpt_pkg::MAX_TABLES-1:0] present_ff;
   logic [tlpt_pkg::MAX_TABLES-1:0] present_in;
   logic                            in_range;

   // A reload clears the directory and marks the first count tables present.
   always_comb begin
      present_in = present_ff;
      if (ctrl.load) begin
         for (int d = 0; d < tlpt_pkg::MAX_TABLES; d++) begin
            present_in[d] = (32'(d) < 32'(ctrl.count));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_in;
      end
   end

   // Indexes at or beyond the table limit never hit.
   assign in_range = ({1'b0, lookup_dir} < (tlpt_pkg::IDX_W + 1)'(tlpt_pkg::MAX_TABLES));
   assign hit      = in_range && present_ff[lookup_dir[tlpt_pkg::DIR_W-1:0]];

endmodule

// ===== rtl/core/two_level_page_table_engine.sv =====
// Top level of the two-level page table engine: request sequencer and result register.
//
//   channel  | ports                                              | handshake
//   request  | req_mode, req_virtual_addr, req_physical_addr,     | start & !busy
//            | req_user_access                                    |
//   result   | rsp_translated_addr, rsp_status                    | rsp_strobe, one cycle
//   config   | csr_memory_mb                                      | csr_we
//
// For map, unmap and translate, the entry is read from the page table RAM in the accept
// cycle and checked and written back in the next one.
// Init fills n*1024 entries, n being the number of tables it fills, one RAM write per
// cycle; an init that fills no table writes no entry.
// The result appears in the cycle after the last busy cycle.
// Reset clears the directory, the memory size register, the result strobe and the
// sequencer; the page table RAM is not cleared. The receiver cannot stall, so nothing waits on it.
module two_level_page_table_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tlpt_pkg::MODE_W-1:0]   req_mode,
   input  logic [tlpt_pkg::VA_W-1:0]     req_virtual_addr,
   input  logic [tlpt_pkg::VA_W-1:0]     req_physical_addr,
   input  logic                          req_user_access,
   output logic                          rsp_strobe,
   output logic [tlpt_pkg::VA_W-1:0]     rsp_translated_addr,
   output logic [tlpt_pkg::STAT_W-1:0]   rsp_status,
   input  logic                          csr_we,
   input  logic [tlpt_pkg::MB_W-1:0]     csr_memory_mb
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_INIT   = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [tlpt_pkg::MB_W-1:0]          memory_mb_ff;
   logic [tlpt_pkg::MODE_W-1:0]        mode_ff;
   logic [tlpt_pkg::VA_W-1:0]          va_ff;
   logic [tlpt_pkg::VA_W-1:0]          pa_ff;
   logic                               user_ff;
   logic [tlpt_pkg::ADDR_W-1:0]        slot_ff;
   logic [tlpt_pkg::ADDR_W-1:0]        slot_in;
   logic [tlpt_pkg::ADDR_W-1:0]        init_addr_ff, init_addr_in;
   logic [tlpt_pkg::ADDR_W-1:0]        init_last_ff;
   logic                               init_nz_ff;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [tlpt_pkg::VA_W-1:0]          rsp_addr_ff, rsp_addr_in;
   logic [tlpt_pkg::STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                               accept;
   logic [5:0]                         n_raw;
   logic [tlpt_pkg::CNT_W-1:0]         n_sat;
   logic [tlpt_pkg::CNT_W+9:0]         n_words;
   tlpt_pkg::dir_ctrl_type             dir_ctrl;
   logic                               dir_hit;
   logic                               ram_wr_en;
   logic [tlpt_pkg::ADDR_W-1:0]        ram_wr_addr;
   logic [tlpt_pkg::ENTRY_W-1:0]       ram_wr_data;
   logic [tlpt_pkg::ENTRY_W-1:0]       ram_rd_data;
   logic                               entry_present;
   logic                               init_done;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Slot of the requested page: directory index over entry index.
   assign slot_in = tlpt_pkg::ADDR_W'({req_virtual_addr[tlpt_pkg::IDX_W+tlpt_pkg::DIR_W+11:22],
                                       req_virtual_addr[21:12]});

   // Table count for init: ceil(mb/4), saturated to the table limit.
   assign n_raw   = 6'((8'(memory_mb_ff) + 8'd3) >> 2);
   assign n_sat   = (32'(n_raw) > 32'(tlpt_pkg::MAX_TABLES)) ?
                    tlpt_pkg::CNT_W'(tlpt_pkg::MAX_TABLES) : tlpt_pkg::CNT_W'(n_raw);
   assign n_words = {n_sat, 10'b0} - (tlpt_pkg::CNT_W + 10)'(1);

   assign dir_ctrl.load  = accept && (req_mode == tlpt_pkg::MODE_INIT);
   assign dir_ctrl.count = n_sat;

   tlpt_dir u_dir (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (dir_ctrl),
      .lookup_dir (va_ff[31:22]),
      .hit        (dir_hit)
   );

   tlpt_ram #(
      .WIDTH (tlpt_pkg::ENTRY_W),
      .DEPTH (tlpt_pkg::PT_DEPTH)
   ) u_pt_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (slot_in),
      .rd_data (ram_rd_data)
   );

   assign entry_present = ram_rd_data[0];
   assign init_done     = !init_nz_ff || (init_addr_ff == init_last_ff);

   // Sequencer: checks, write-back and result for each state.
   always_comb begin
      state_in      = state_ff;
      init_addr_in  = init_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = tlpt_pkg::ST_OK;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               init_addr_in = '0;
               state_in     = (req_mode == tlpt_pkg::MODE_INIT) ? S_INIT : S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            case (mode_ff)
               tlpt_pkg::MODE_MAP: begin
                  if (va_ff[tlpt_pkg::OFFS_W-1:0] != '0) begin
                     rsp_status_in = tlpt_pkg::ST_VIRT_MISALIGNED;
                  end else if (pa_ff[tlpt_pkg::OFFS_W-1:0] != '0) begin
                     rsp_status_in = tlpt_pkg::ST_PHYS_MISALIGNED;
                  end else if (!dir_hit) begin
                     rsp_status_in = tlpt_pkg::ST_NO_TABLE;
                  end else if (entry_present) begin
                     rsp_status_in = tlpt_pkg::ST_ALREADY_MAPPED;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {pa_ff[31:12], user_ff, 1'b1, 1'b1};
                  end
               end
               tlpt_pkg::MODE_UNMAP: begin
                  if (va_ff[tlpt_pkg::OFFS_W-1:0] != '0) begin
                     rsp_status_in = tlpt_pkg::ST_VIRT_MISALIGNED;
                  end else if (!dir_hit) begin
                     rsp_status_in = tlpt_pkg::ST_NO_TABLE;
                  end else if (!entry_present) begin
                     rsp_status_in = tlpt_pkg::ST_NOT_MAPPED;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = '0;
                  end
               end
               tlpt_pkg::MODE_TRANSLATE: begin
                  if (!dir_hit) begin
                     rsp_status_in = tlpt_pkg::ST_NO_TABLE;
                  end else begin
                     rsp_addr_in = {ram_rd_data[tlpt_pkg::ENTRY_W-1:3],
                                    va_ff[tlpt_pkg::OFFS_W-1:0]};
                  end
               end
               default: begin
                  rsp_status_in = tlpt_pkg::ST_OK;
               end
            endcase
         end
         S_INIT: begin
            // Identity-map one entry per cycle across the present tables.
            ram_wr_en    = init_nz_ff;
            ram_wr_addr  = init_addr_ff;
            ram_wr_data  = {tlpt_pkg::FRAME_W'(init_addr_ff), 3'b001};
            init_addr_in = init_addr_ff + tlpt_pkg::ADDR_W'(1);
            if (init_done) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         memory_mb_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            memory_mb_ff <= csr_memory_mb;
         end
      end
   end

   // Request and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff      <= req_mode;
         va_ff        <= req_virtual_addr;
         pa_ff        <= req_physical_addr;
         user_ff      <= req_user_access;
         slot_ff      <= slot_in;
         init_nz_ff   <= (n_sat != '0);
         init_last_ff <= n_words[tlpt_pkg::ADDR_W-1:0];
      end
      init_addr_ff  <= init_addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_translated_addr = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

`ifndef SYNTH
   // A result beat always lands while the sequencer is back at idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == S_IDLE))
      else $error("result beat while sequencer busy");

   // Only a successful translate carries a nonzero address.
   a_rsp_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != tlpt_pkg::ST_OK)) |-> (rsp_translated_addr == '0))
      else $error("failed request returned an address");

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start work");

   // The page table is written only while a request is in progress.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> busy)
      else $error("page table write while idle");
`endif

endmodule
